// ===== rtl/sca_pkg.sv =====
// shared constants and controller/datapath types for the supply compensated averager
package sca_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int REF_MV_W    = 11;
  localparam int RATIO_W     = 5;
  localparam int BATT_W      = 16;
  localparam int SCALE_SHIFT = 12;
  localparam int QUO_W       = REF_MV_W + SCALE_SHIFT;
  localparam int PROD_W      = SAMPLE_W + RATIO_W;
  localparam int MUL_W       = PROD_W + QUO_W;
  localparam int CNT_W       = $clog2(QUO_W);

  // averaging factor, a power of two
  localparam int AVG_FACTOR  = 16;
  localparam int AVG_SHIFT   = $clog2(AVG_FACTOR);
  localparam int BATT_SUM_W  = $clog2((2 ** BATT_W) * AVG_FACTOR);
  localparam int LIGHT_SUM_W = $clog2((2 ** SAMPLE_W) * AVG_FACTOR);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = REF_MV_W;

  localparam logic [CFG_IDX_W-1:0] REG_REF_MV    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_RATIO = 1'b1;

  localparam logic [REF_MV_W-1:0] REF_MV_RESET = 11'd1200;
  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 5'd2;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_load;
    logic commit;
  } sca_cmd_t;

  typedef struct packed {
    logic ref_zero;
  } sca_status_t;

endpackage

// ===== rtl/sca_ctrl.sv =====
// sequencing controller: accept, divide, multiply, update and output handshake
module sca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  sca_pkg::sca_status_t  status,
  output sca_pkg::sca_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [sca_pkg::CNT_W-1:0]   count;
  logic [sca_pkg::CNT_W-1:0]   count_next;
  logic                        result_valid_next;
  logic                        out_free;
  logic                        accept;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = status.ref_zero ? S_UPD : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + 1'b1;
        if (count == sca_pkg::CNT_W'(sca_pkg::QUO_W - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result_valid_next = cmd.commit || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("second transaction accepted while busy");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("committed result not presented");

  a_mul_to_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_load |=> (state == S_UPD))
    else $error("multiply not followed by update");

endmodule

// ===== rtl/sca_datapath.sv =====
// datapath: config registers, restoring divider, scaling multiplier and average sums
module sca_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [sca_pkg::SAMPLE_W-1:0]     light_sample,
  input  logic [sca_pkg::SAMPLE_W-1:0]     battery_sample,
  input  logic [sca_pkg::SAMPLE_W-1:0]     reference_sample,
  input  sca_pkg::sca_cmd_t                cmd,
  output sca_pkg::sca_status_t             status,
  output logic [sca_pkg::BATT_W-1:0]       battery_average_mv,
  output logic [sca_pkg::SAMPLE_W-1:0]     light_average,
  output logic                             reference_fault
);

  logic [sca_pkg::REF_MV_W-1:0]    ref_mv;
  logic [sca_pkg::RATIO_W-1:0]     div_ratio;
  logic [sca_pkg::SAMPLE_W-1:0]    light_hold;
  logic [sca_pkg::SAMPLE_W-1:0]    divisor;
  logic [sca_pkg::PROD_W-1:0]      batt_scaled;
  logic                            fault_hold;
  logic [sca_pkg::QUO_W-1:0]       quo;
  logic [sca_pkg::SAMPLE_W-1:0]    rem;
  logic [sca_pkg::BATT_W-1:0]      batt_mv;
  logic [sca_pkg::BATT_SUM_W-1:0]  battery_sum;
  logic [sca_pkg::LIGHT_SUM_W-1:0] light_sum;

  logic [sca_pkg::SAMPLE_W:0]      rem_shift;
  logic                            rem_ge;
  logic [sca_pkg::SAMPLE_W:0]      rem_diff;
  logic [sca_pkg::MUL_W-1:0]       product;
  logic [sca_pkg::BATT_SUM_W:0]    batt_ema;
  logic [sca_pkg::LIGHT_SUM_W:0]   light_ema;
  logic [sca_pkg::BATT_SUM_W-1:0]  battery_sum_next;
  logic [sca_pkg::LIGHT_SUM_W-1:0] light_sum_next;

  assign status.ref_zero = (reference_sample == '0);

  // one restoring division step per cycle
  assign rem_shift = {rem, quo[sca_pkg::QUO_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign rem_diff  = rem_shift - {1'b0, divisor};

  assign product = sca_pkg::MUL_W'(batt_scaled) * sca_pkg::MUL_W'(quo);

  // moving average update, seeding an empty sum and holding both sums on a reference fault
  always_comb begin
    if (battery_sum == '0) begin
      batt_ema = (sca_pkg::BATT_SUM_W+1)'(batt_mv) << sca_pkg::AVG_SHIFT;
    end else begin
      batt_ema = {1'b0, battery_sum} - {1'b0, battery_sum >> sca_pkg::AVG_SHIFT}
               + (sca_pkg::BATT_SUM_W+1)'(batt_mv);
    end
    if (light_sum == '0) begin
      light_ema = (sca_pkg::LIGHT_SUM_W+1)'(light_hold) << sca_pkg::AVG_SHIFT;
    end else begin
      light_ema = {1'b0, light_sum} - {1'b0, light_sum >> sca_pkg::AVG_SHIFT}
                + (sca_pkg::LIGHT_SUM_W+1)'(light_hold);
    end
    if (fault_hold) begin
      battery_sum_next = battery_sum;
      light_sum_next   = light_sum;
    end else begin
      battery_sum_next = batt_ema[sca_pkg::BATT_SUM_W-1:0];
      light_sum_next   = light_ema[sca_pkg::LIGHT_SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv      <= sca_pkg::REF_MV_RESET;
      div_ratio   <= sca_pkg::RATIO_RESET;
      battery_sum <= '0;
      light_sum   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          sca_pkg::REG_REF_MV:    ref_mv    <= cfg_data;
          sca_pkg::REG_DIV_RATIO: div_ratio <= cfg_data[sca_pkg::RATIO_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        battery_sum <= battery_sum_next;
        light_sum   <= light_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      light_hold  <= light_sample;
      divisor     <= reference_sample;
      fault_hold  <= status.ref_zero;
      batt_scaled <= sca_pkg::PROD_W'(battery_sample) * sca_pkg::PROD_W'(div_ratio);
      quo         <= {ref_mv, {sca_pkg::SCALE_SHIFT{1'b0}}};
      rem         <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[sca_pkg::QUO_W-2:0], rem_ge};
      rem <= rem_ge ? rem_diff[sca_pkg::SAMPLE_W-1:0] : rem_shift[sca_pkg::SAMPLE_W-1:0];
    end
    if (cmd.mul_load) begin
      if (|product[sca_pkg::MUL_W-1:sca_pkg::SCALE_SHIFT+sca_pkg::BATT_W]) begin
        batt_mv <= '1;
      end else begin
        batt_mv <= product[sca_pkg::SCALE_SHIFT +: sca_pkg::BATT_W];
      end
    end
    if (cmd.commit) begin
      battery_average_mv <= battery_sum_next[sca_pkg::AVG_SHIFT +: sca_pkg::BATT_W];
      light_average      <= light_sum_next[sca_pkg::AVG_SHIFT +: sca_pkg::SAMPLE_W];
      reference_fault    <= fault_hold;
    end
  end

endmodule

// ===== rtl/supply_compensated_sensor_averager.sv =====
// top level of the supply compensated sensor averager
// Takes one transaction of light, battery and reference readings at a time. The operands are
// loaded at the accepting edge. A normal transaction passes through the bit-per-cycle restoring
// divider that derives the supply voltage, then the battery scaling multiply, then the update
// of the averages into the output register. A zero reference reading skips the divider and
// multiply and returns the unchanged averages with reference_fault set. The update waits
// while an earlier result is still stalled in the output register. The next transaction is
// accepted in the cycle after the result is written to the output register, so the block does
// not take a new transaction before it is through with the last one.
module supply_compensated_sensor_averager (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [sca_pkg::SAMPLE_W-1:0]     light_sample,
  input  logic [sca_pkg::SAMPLE_W-1:0]     battery_sample,
  input  logic [sca_pkg::SAMPLE_W-1:0]     reference_sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [sca_pkg::BATT_W-1:0]       battery_average_mv,
  output logic [sca_pkg::SAMPLE_W-1:0]     light_average,
  output logic                             reference_fault
);

  sca_pkg::sca_cmd_t    cmd;
  sca_pkg::sca_status_t status;

  sca_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sca_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .light_sample       (light_sample),
    .battery_sample     (battery_sample),
    .reference_sample   (reference_sample),
    .cmd                (cmd),
    .status             (status),
    .battery_average_mv (battery_average_mv),
    .light_average      (light_average),
    .reference_fault    (reference_fault)
  );

endmodule
